// ----- hdl/gfd_pkg.sv -----
// ----------------------------------------------------------------------------
// gfd_pkg
// Shared types, codes and constants for the GNSS frame deframer.
// ----------------------------------------------------------------------------
package gfd_pkg;

  // Size of the downstream message store; byte positions below this are kept.
  localparam int unsigned StoreDepth = 1024;

  localparam int unsigned IdxW   = 17;
  localparam int unsigned CountW = 16;

  localparam logic [IdxW-1:0]   IndexMax  = {IdxW{1'b1}};
  localparam logic [CountW-1:0] CountMax  = {CountW{1'b1}};
  localparam logic [7:0]        FillerByte  = 8'hFF;
  localparam logic [7:0]        NewlineByte = 8'h0A;
  localparam logic [IdxW-1:0]   BinOverhead = 17'd8;

  localparam logic [7:0]        TextStartReset = 8'd36;
  localparam logic [7:0]        BinSyncReset   = 8'd181;
  localparam logic [CountW-1:0] ByteLimitReset = 16'd10000;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_TEXT     = 3'd1,
    EV_BIN_OK   = 3'd2,
    EV_BIN_BAD  = 3'd3,
    EV_UNKNOWN  = 3'd4,
    EV_FILLER   = 3'd5
  } gfd_event_t;

  typedef enum logic [1:0] {
    END_DONE    = 2'd0,
    END_NO_DATA = 2'd1,
    END_CSUM    = 2'd2
  } gfd_end_t;

  typedef enum logic [1:0] {
    CFG_TEXT_START = 2'd0,
    CFG_BIN_SYNC   = 2'd1,
    CFG_BYTE_LIMIT = 2'd2
  } gfd_cfg_idx_t;

  typedef struct packed {
    logic [7:0]        text_start_char;
    logic [7:0]        binary_sync_char;
    logic [CountW-1:0] byte_limit;
  } gfd_cfg_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic [7:0] tx_byte;
    logic       tx_active;
    logic       last_tx;
    logic       rx_only;
    logic       first_of_transaction;
  } gfd_item_t;

  typedef struct packed {
    logic [IdxW-1:0]   frame_index;
    logic              text_mode;
    logic [IdxW-1:0]   frame_length;
    logic [7:0]        sum_a;
    logic [7:0]        sum_b;
    logic              sum_a_matched;
    logic [CountW-1:0] exchange_count;
    logic [7:0]        len_low;
  } gfd_state_t;

  typedef struct packed {
    logic [7:0]      mosi_byte;
    gfd_event_t      event_res;
    logic [IdxW-1:0] message_length;
    logic [IdxW-1:0] byte_index;
    logic            store_enable;
    logic            is_text;
    logic            transaction_end;
    gfd_end_t        end_status;
  } gfd_res_t;

endpackage

// ----- hdl/gfd_step.sv -----
// ----------------------------------------------------------------------------
// gfd_step
// Per-byte framing logic: next frame state and the result for one exchange.
// ----------------------------------------------------------------------------
module gfd_step (
  input  gfd_pkg::gfd_cfg_t   cfg,
  input  gfd_pkg::gfd_state_t st,
  input  gfd_pkg::gfd_item_t  item,
  output gfd_pkg::gfd_state_t st_next,
  output gfd_pkg::gfd_res_t   res
);

  gfd_pkg::gfd_state_t        cur;
  gfd_pkg::gfd_state_t        nxt;
  logic [gfd_pkg::IdxW-1:0]   pos;
  logic [gfd_pkg::IdxW-1:0]   pos_sat;
  logic [gfd_pkg::IdxW-1:0]   msg_len;
  logic [gfd_pkg::IdxW-1:0]   idx_out;
  logic [7:0]                 sum_a_new;
  gfd_pkg::gfd_event_t        ev;
  gfd_pkg::gfd_end_t          status;
  logic                       end_flag;
  logic                       forced;
  logic                       done;
  logic                       csum_ok;
  logic                       more;

  always_comb begin
    cur = st;
    if (item.first_of_transaction) begin
      cur.frame_index    = '0;
      cur.frame_length   = '0;
      cur.sum_a          = '0;
      cur.sum_b          = '0;
      cur.sum_a_matched  = 1'b0;
      cur.len_low        = '0;
      cur.exchange_count = '0;
    end

    nxt       = cur;
    pos       = cur.frame_index;
    pos_sat   = (pos == gfd_pkg::IndexMax) ? pos : pos + 1'b1;
    msg_len   = '0;
    ev        = gfd_pkg::EV_NONE;
    status    = gfd_pkg::END_DONE;
    end_flag  = 1'b0;
    forced    = 1'b0;
    done      = 1'b0;
    csum_ok   = 1'b0;
    sum_a_new = '0;

    if (pos == '0 && item.rx_byte != cfg.text_start_char &&
        item.rx_byte != cfg.binary_sync_char) begin
      // Nothing opens here: idle filler or a stray byte.
      if (item.rx_byte == gfd_pkg::FillerByte) begin
        ev = gfd_pkg::EV_FILLER;
        if (item.rx_only) begin
          end_flag = 1'b1;
          forced   = 1'b1;
          status   = gfd_pkg::END_NO_DATA;
        end
      end else begin
        ev = gfd_pkg::EV_UNKNOWN;
      end
    end else begin
      if (pos == '0) begin
        nxt.text_mode     = (item.rx_byte == cfg.text_start_char);
        nxt.sum_a         = '0;
        nxt.sum_b         = '0;
        nxt.sum_a_matched = 1'b0;
        nxt.frame_length  = '0;
      end

      if (nxt.text_mode) begin
        if (item.rx_byte == gfd_pkg::NewlineByte) begin
          msg_len         = pos_sat;
          ev              = gfd_pkg::EV_TEXT;
          done            = 1'b1;
          nxt.frame_index = '0;
          if (!item.tx_active) begin
            end_flag = 1'b1;
            forced   = 1'b1;
          end
        end
      end else begin
        if (pos == 17'd4) begin
          nxt.len_low = item.rx_byte;
        end
        if (pos == 17'd5) begin
          nxt.frame_length = {1'b0, item.rx_byte, nxt.len_low} + gfd_pkg::BinOverhead;
        end
        // Fletcher sums cover class, id, length and payload.
        if (pos >= 17'd2 &&
            (pos <= 17'd5 || ({1'b0, pos} + 18'd3) <= {1'b0, nxt.frame_length})) begin
          sum_a_new = nxt.sum_a + item.rx_byte;
          nxt.sum_a = sum_a_new;
          nxt.sum_b = nxt.sum_b + sum_a_new;
        end else if (nxt.frame_length != '0 &&
                     ({1'b0, pos} + 18'd2) == {1'b0, nxt.frame_length}) begin
          nxt.sum_a_matched = (item.rx_byte == nxt.sum_a);
        end else if (nxt.frame_length != '0 &&
                     ({1'b0, pos} + 18'd1) == {1'b0, nxt.frame_length}) begin
          csum_ok           = nxt.sum_a_matched && (item.rx_byte == nxt.sum_b);
          ev                = csum_ok ? gfd_pkg::EV_BIN_OK : gfd_pkg::EV_BIN_BAD;
          msg_len           = nxt.frame_length;
          done              = 1'b1;
          nxt.frame_index   = '0;
          nxt.frame_length  = '0;
          nxt.sum_a         = '0;
          nxt.sum_b         = '0;
          nxt.sum_a_matched = 1'b0;
          nxt.len_low       = '0;
          if (!item.tx_active) begin
            end_flag = 1'b1;
            forced   = 1'b1;
            status   = csum_ok ? gfd_pkg::END_DONE : gfd_pkg::END_CSUM;
          end
        end
      end

      if (!done) begin
        nxt.frame_index = pos_sat;
      end
    end

    more = (item.tx_active && !item.last_tx) || (nxt.frame_index != '0) || item.rx_only;
    if (!forced) begin
      if (!more || ({1'b0, cur.exchange_count} + 17'd1) >= {1'b0, cfg.byte_limit}) begin
        end_flag = 1'b1;
        status   = gfd_pkg::END_DONE;
      end
    end

    if (cur.exchange_count != gfd_pkg::CountMax) begin
      nxt.exchange_count = cur.exchange_count + 1'b1;
    end

    idx_out = (ev == gfd_pkg::EV_UNKNOWN || ev == gfd_pkg::EV_FILLER) ? '0 : pos;
  end

  assign st_next = nxt;

  always_comb begin
    res.mosi_byte       = item.tx_active ? item.tx_byte : gfd_pkg::FillerByte;
    res.event_res       = ev;
    res.message_length  = msg_len;
    res.byte_index      = idx_out;
    res.store_enable    = (idx_out < gfd_pkg::IdxW'(gfd_pkg::StoreDepth));
    res.is_text         = nxt.text_mode;
    res.transaction_end = end_flag;
    res.end_status      = end_flag ? status : gfd_pkg::END_DONE;
  end

endmodule

// ----- hdl/gnss_frame_deframer_unit.sv -----
// ----------------------------------------------------------------------------
// gnss_frame_deframer_unit
// Frames text sentences and binary frames from full-duplex SPI byte pairs.
// ----------------------------------------------------------------------------
// Usage
//   Each slave-side transfer carries one SPI exchange: the byte received from
//   the navigation receiver, the host byte to send and the transaction flags.
//   Each master-side transfer returns the byte to drive out (the host byte, or
//   0xFF filler once the packet is sent), the framing event, the length of a
//   frame just completed, the position of the byte in its frame, and on
//   tlast the end of the SPI transaction with its reason.
//   The result of an input is registered; an input can be taken every cycle
//   while results drain. The framing state lives in one register set that is
//   updated in the same cycle the input is taken, so items follow back to back.
//   A single output register holds the result; a new input is taken whenever
//   that register is empty or being emptied in the same cycle, so a stalled
//   receiver stops the input side after one item and nothing is lost.
//   Reset clears the frame state, the exchange count and the output valid flag
//   and loads the start character, sync character and byte limit defaults.
//   The configuration channel is always ready; writes to an index beyond the
//   register list are accepted and ignored. Write it only while idle.
// ----------------------------------------------------------------------------
module gnss_frame_deframer_unit (
  input  logic        clk,
  input  logic        rst,
  // Input exchanges
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [7:0] rx_byte, [15:8] tx_byte
  input  logic [2:0]  s_tuser,   // [0] tx_active, [1] rx_only, [2] first_of_transaction
  input  logic        s_tlast,   // last_tx
  // Results
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // [7:0] mosi_byte, [24:8] message_length,
                                 // [41:25] byte_index, [42] store_enable,
                                 // [43] is_text, [45:44] end_status, [47:46] zero
  output logic [2:0]  m_tuser,   // [2:0] event_res
  output logic        m_tlast,   // transaction_end
  // Register writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  gfd_pkg::gfd_cfg_t   cfg;
  gfd_pkg::gfd_state_t st;
  gfd_pkg::gfd_state_t st_next;
  gfd_pkg::gfd_item_t  item;
  gfd_pkg::gfd_res_t   step_res;
  gfd_pkg::gfd_res_t   res;
  logic                out_valid;
  logic                s_accept;

  assign cfg_ready = 1'b1;

  // Register file: only the listed indices have storage.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.text_start_char  <= gfd_pkg::TextStartReset;
      cfg.binary_sync_char <= gfd_pkg::BinSyncReset;
      cfg.byte_limit       <= gfd_pkg::ByteLimitReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        gfd_pkg::CFG_TEXT_START: cfg.text_start_char  <= cfg_data[7:0];
        gfd_pkg::CFG_BIN_SYNC:   cfg.binary_sync_char <= cfg_data[7:0];
        gfd_pkg::CFG_BYTE_LIMIT: cfg.byte_limit       <= cfg_data;
        default: ;
      endcase
    end
  end

  // Unpack the input transfer.
  always_comb begin
    item.rx_byte              = s_tdata[7:0];
    item.tx_byte              = s_tdata[15:8];
    item.tx_active            = s_tuser[0];
    item.last_tx              = s_tlast;
    item.rx_only              = s_tuser[1];
    item.first_of_transaction = s_tuser[2];
  end

  gfd_step u_step (
    .cfg     (cfg),
    .st      (st),
    .item    (item),
    .st_next (st_next),
    .res     (step_res)
  );

  // The output register frees up in the same cycle the receiver takes it.
  assign s_tready = !out_valid || m_tready;
  assign s_accept = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (s_accept) begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_accept) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      res <= step_res;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = res.event_res;
  assign m_tlast  = res.transaction_end;
  assign m_tdata  = {2'b00, res.end_status, res.is_text, res.store_enable,
                     res.byte_index, res.message_length, res.mosi_byte};

  // A binary frame completion always leaves the frame state cleared.
  assert property (@(posedge clk) disable iff (rst)
    ($past(s_accept) && (res.event_res == gfd_pkg::EV_BIN_OK ||
                         res.event_res == gfd_pkg::EV_BIN_BAD)) |->
      (st.frame_index == '0 && st.frame_length == '0))
    else $error("frame state not cleared after binary frame");

  // An end reason other than done only appears on a transaction end.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.end_status != gfd_pkg::END_DONE) |-> res.transaction_end)
    else $error("end status without transaction end");

  // A frame length is reported only with a completion event.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && res.message_length != '0) |->
      (res.event_res == gfd_pkg::EV_TEXT || res.event_res == gfd_pkg::EV_BIN_OK ||
       res.event_res == gfd_pkg::EV_BIN_BAD))
    else $error("message length without completion");

  // Filler and stray bytes sit outside any frame.
  assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res.event_res == gfd_pkg::EV_UNKNOWN ||
                  res.event_res == gfd_pkg::EV_FILLER)) |->
      (res.byte_index == '0 && res.store_enable))
    else $error("non-frame byte given a frame position");

  // An empty output register never blocks the input side.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> s_tready)
    else $error("input stalled with empty output register");

endmodule

// ----- verif/gfd_deframe_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// gfd_deframe_checker
// Watches the exchange, result and register channels of the deframer. It
// keeps its own copy of the framing state, works out the result of every
// accepted exchange and compares each returned result field by field.
// ----------------------------------------------------------------------------
module gfd_deframe_checker
  import gfd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [2:0]  s_tuser,
  input  logic        s_tlast,
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [47:0] m_tdata,
  input  logic [2:0]  m_tuser,
  input  logic        m_tlast,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatches,
  output int          pending,
  output int          n_results,
  output int          n_text,
  output int          n_bin_ok,
  output int          n_bin_bad,
  output int          n_ends
);

  // Register copies.
  logic [7:0]        start_ch;
  logic [7:0]        sync_ch;
  logic [CountW-1:0] byte_lim;

  // Framing state.
  logic [IdxW-1:0]   f_index;
  bit                txt;
  logic [IdxW-1:0]   f_len;
  logic [7:0]        sa;
  logic [7:0]        sb;
  bit                sa_ok;
  logic [CountW-1:0] xfer_cnt;
  logic [7:0]        lo_len;

  gfd_res_t exchange_results_q[$];
  int       fails;

  function automatic void clear_frame();
    f_index = '0;
    f_len   = '0;
    sa      = '0;
    sb      = '0;
    sa_ok   = 1'b0;
    lo_len  = '0;
  endfunction

  // Frames one received byte and returns what the block reports for it.
  function automatic gfd_res_t frame_exchange(gfd_item_t it);
    gfd_res_t    r;
    logic [7:0]  rx;
    int unsigned pos;
    int unsigned mlen;
    int unsigned idx;
    gfd_event_t  ev;
    gfd_end_t    st;
    bit          fin;
    bit          forced;
    bit          done;
    bit          ok;
    bit          more;
    rx     = it.rx_byte;
    ev     = EV_NONE;
    st     = END_DONE;
    mlen   = 0;
    fin    = 1'b0;
    forced = 1'b0;
    done   = 1'b0;
    if (it.first_of_transaction) begin
      clear_frame();
      xfer_cnt = '0;
    end
    pos = 32'(f_index);

    if (pos == 0 && rx != start_ch && rx != sync_ch) begin
      if (rx == FillerByte) begin
        ev = EV_FILLER;
        if (it.rx_only) begin
          fin    = 1'b1;
          forced = 1'b1;
          st     = END_NO_DATA;
        end
      end else begin
        ev = EV_UNKNOWN;
      end
    end else begin
      if (pos == 0) begin
        txt   = (rx == start_ch);
        sa    = '0;
        sb    = '0;
        sa_ok = 1'b0;
        f_len = '0;
      end
      if (txt) begin
        if (rx == NewlineByte) begin
          mlen    = (pos >= IndexMax) ? IndexMax : pos + 1;
          ev      = EV_TEXT;
          done    = 1'b1;
          f_index = '0;
          if (!it.tx_active) begin
            fin    = 1'b1;
            forced = 1'b1;
          end
        end
      end else begin
        if (pos == 4) lo_len = rx;
        if (pos == 5) f_len = {1'b0, rx, lo_len} + BinOverhead;
        if (pos >= 2 && (pos <= 5 || pos + 3 <= f_len)) begin
          sa = sa + rx;
          sb = sb + sa;
        end else if (f_len != 0 && pos + 2 == f_len) begin
          sa_ok = (rx == sa);
        end else if (f_len != 0 && pos + 1 == f_len) begin
          ok   = sa_ok && (rx == sb);
          ev   = ok ? EV_BIN_OK : EV_BIN_BAD;
          mlen = 32'(f_len);
          done = 1'b1;
          clear_frame();
          if (!it.tx_active) begin
            fin    = 1'b1;
            forced = 1'b1;
            st     = ok ? END_DONE : END_CSUM;
          end
        end
      end
      if (!done) f_index = IdxW'((pos >= IndexMax) ? IndexMax : pos + 1);
    end

    if (!forced) begin
      more = (it.tx_active && !it.last_tx) || f_index != 0 || it.rx_only;
      if (!more || int'(xfer_cnt) + 1 >= int'(byte_lim)) begin
        fin = 1'b1;
        st  = END_DONE;
      end
    end
    if (xfer_cnt != CountMax) xfer_cnt = xfer_cnt + 1'b1;

    idx = (ev >= EV_UNKNOWN) ? 0 : pos;
    r.mosi_byte       = it.tx_active ? it.tx_byte : FillerByte;
    r.event_res       = ev;
    r.message_length  = IdxW'(mlen);
    r.byte_index      = IdxW'(idx);
    r.store_enable    = (idx < StoreDepth);
    r.is_text         = txt;
    r.transaction_end = fin;
    r.end_status      = fin ? st : END_DONE;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk) begin : watch
    gfd_item_t it;
    gfd_res_t  want;
    gfd_res_t  got;
    if (rst) begin
      start_ch = TextStartReset;
      sync_ch  = BinSyncReset;
      byte_lim = ByteLimitReset;
      txt      = 1'b0;
      xfer_cnt = '0;
      clear_frame();
      exchange_results_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_TEXT_START: start_ch = cfg_data[7:0];
          CFG_BIN_SYNC:   sync_ch  = cfg_data[7:0];
          CFG_BYTE_LIMIT: byte_lim = cfg_data;
          default: ;
        endcase
      end
      // The result leaving now belongs to an earlier exchange, so pop first.
      if (m_tvalid && m_tready) begin
        if (exchange_results_q.size() == 0) begin
          $error("result transfer with no exchange outstanding");
          fails++;
        end else begin
          want = exchange_results_q.pop_front();
          got.mosi_byte       = m_tdata[7:0];
          got.event_res       = gfd_event_t'(m_tuser);
          got.message_length  = m_tdata[24:8];
          got.byte_index      = m_tdata[41:25];
          got.store_enable    = m_tdata[42];
          got.is_text         = m_tdata[43];
          got.transaction_end = m_tlast;
          got.end_status      = gfd_end_t'(m_tdata[45:44]);
          check_field("mosi_byte", want.mosi_byte, got.mosi_byte);
          check_field("event_res", want.event_res, got.event_res);
          check_field("message_length", want.message_length, got.message_length);
          check_field("byte_index", want.byte_index, got.byte_index);
          check_field("store_enable", want.store_enable, got.store_enable);
          check_field("is_text", want.is_text, got.is_text);
          check_field("transaction_end", want.transaction_end, got.transaction_end);
          check_field("end_status", want.end_status, got.end_status);
          n_results <= n_results + 1;
          if (want.event_res == EV_TEXT)    n_text    <= n_text + 1;
          if (want.event_res == EV_BIN_OK)  n_bin_ok  <= n_bin_ok + 1;
          if (want.event_res == EV_BIN_BAD) n_bin_bad <= n_bin_bad + 1;
          if (want.transaction_end)         n_ends    <= n_ends + 1;
        end
      end
      if (s_tvalid && s_tready) begin
        it.rx_byte              = s_tdata[7:0];
        it.tx_byte              = s_tdata[15:8];
        it.tx_active            = s_tuser[0];
        it.rx_only              = s_tuser[1];
        it.first_of_transaction = s_tuser[2];
        it.last_tx              = s_tlast;
        exchange_results_q.push_back(frame_exchange(it));
      end
    end
    pending    <= exchange_results_q.size();
    mismatches <= fails;
  end

  initial begin
    fails      = 0;
    mismatches = 0;
    pending    = 0;
    n_results  = 0;
    n_text     = 0;
    n_bin_ok   = 0;
    n_bin_bad  = 0;
    n_ends     = 0;
  end

endmodule

// ----- verif/tb_gnss_frame_deframer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_gnss_frame_deframer_unit
// Drives SPI byte exchanges into the GNSS frame deframer: a short directed
// opening, then random transactions of text sentences, binary frames, filler
// and noise under several register settings, and finally a binary frame that
// runs past the end of the message store. A separate checker predicts and
// compares every result.
// ----------------------------------------------------------------------------
module tb_gnss_frame_deframer_unit;
  import gfd_pkg::*;

  // Writes to this index lie outside the register list and must be ignored.
  localparam logic [1:0] CfgSpare = 2'd3;

  // Random exchanges per register setting; eight settings are visited.
  localparam int PhaseItems = 50;

  // Length of the one long hold-off on the result side, in cycles.
  localparam int HoldCycles = 400;

  logic        clk = 1'b0;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;
  logic [2:0]  s_tuser;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [47:0] m_tdata;
  logic [2:0]  m_tuser;
  logic        m_tlast;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  int mismatches;
  int pending;
  int n_results;
  int n_text;
  int n_bin_ok;
  int n_bin_bad;
  int n_ends;

  // Register values currently loaded, so that frames can be built to match.
  logic [7:0] cur_start;
  logic [7:0] cur_sync;

  // Received bytes of the transaction being assembled.
  logic [7:0] rx_stream[$];

  int n_sent;
  int n_settings;
  bit s_calm;

  always #1 clk = ~clk;

  gnss_frame_deframer_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  gfd_deframe_checker u_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .mismatches (mismatches),
    .pending    (pending),
    .n_results  (n_results),
    .n_text     (n_text),
    .n_bin_ok   (n_bin_ok),
    .n_bin_bad  (n_bin_bad),
    .n_ends     (n_ends)
  );

  function automatic gfd_item_t mk_item(logic [7:0] rx, logic [7:0] tx, logic act,
                                        logic last, logic ro, logic first);
    gfd_item_t it;
    it.rx_byte              = rx;
    it.tx_byte              = tx;
    it.tx_active            = act;
    it.last_tx              = last;
    it.rx_only              = ro;
    it.first_of_transaction = first;
    return it;
  endfunction

  // Any byte but the newline, so that a sentence body never closes early.
  function automatic logic [7:0] text_byte();
    logic [7:0] b;
    b = 8'($urandom_range(0, 255));
    if (b == NewlineByte) b = 8'h20;
    return b;
  endfunction

  // Appends a sentence: start character, body, newline.
  function automatic void add_sentence(input int body_len);
    rx_stream.push_back(cur_start);
    repeat (body_len) rx_stream.push_back(text_byte());
    rx_stream.push_back(NewlineByte);
  endfunction

  // Appends a binary frame. The checksum is the 8-bit Fletcher pair over
  // class, id, length and payload. A spoilt frame has one checksum byte
  // disturbed; a cut frame stops somewhere after its length field, so the
  // bytes that follow are swallowed as the rest of it.
  function automatic void add_binary(input int plen, input bit spoil, input bit cut);
    logic [7:0] fr[$];
    logic [7:0] ck_a;
    logic [7:0] ck_b;
    logic [7:0] flip;
    int         keep;
    fr.push_back(cur_sync);
    fr.push_back(8'h62);
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(8'($urandom_range(0, 255)));
    fr.push_back(plen[7:0]);
    fr.push_back(plen[15:8]);
    repeat (plen) fr.push_back(8'($urandom_range(0, 255)));
    ck_a = '0;
    ck_b = '0;
    for (int k = 2; k < fr.size(); k++) begin
      ck_a = ck_a + fr[k];
      ck_b = ck_b + ck_a;
    end
    if (spoil) begin
      flip = 8'($urandom_range(1, 255));
      if ($urandom_range(0, 1)) ck_a = ck_a ^ flip;
      else ck_b = ck_b ^ flip;
    end
    fr.push_back(ck_a);
    fr.push_back(ck_b);
    keep = cut ? $urandom_range(6, fr.size() - 1) : fr.size();
    for (int k = 0; k < keep; k++) rx_stream.push_back(fr[k]);
  endfunction

  // Offers one exchange after a random gap and waits for its transfer. A
  // zero gap keeps tvalid high straight into the next item. Now and then the
  // sender flips into or out of a stretch with no gaps at all.
  task automatic offer(input gfd_item_t it);
    int gap;
    if ($urandom_range(0, 31) == 0) s_calm = !s_calm;
    gap = s_calm ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tdata  <= {it.tx_byte, it.rx_byte};
    s_tuser  <= {it.first_of_transaction, it.rx_only, it.tx_active};
    s_tlast  <= it.last_tx;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    n_sent++;
  endtask

  // Plays the assembled bytes as one transaction: the first n_tx exchanges
  // carry the host packet, the rest send filler. Unless tidy, a few items get
  // scrambled flags or a stray start of transaction.
  task automatic play(input int n_tx, input bit ro, input bit tidy);
    gfd_item_t it;
    int        n;
    while (rx_stream.size() < n_tx) rx_stream.push_back(FillerByte);
    n = rx_stream.size();
    for (int i = 0; i < n; i++) begin
      it = mk_item(rx_stream[i], 8'($urandom_range(0, 255)), i < n_tx, i == n_tx - 1,
                   ro, i == 0);
      if (!tidy && $urandom_range(0, 19) == 0) begin
        it.tx_active = 1'($urandom_range(0, 1));
        it.last_tx   = 1'($urandom_range(0, 1));
        it.rx_only   = 1'($urandom_range(0, 1));
      end
      if (!tidy && $urandom_range(0, 99) == 0) it.first_of_transaction = 1'b1;
      offer(it);
    end
    rx_stream.delete();
  endtask

  // A transaction of mostly well-formed frames with some noise mixed in.
  task automatic random_transaction();
    int n_tx;
    bit ro;
    ro   = ($urandom_range(0, 3) == 0);
    n_tx = ro ? 0 : $urandom_range(1, 10);
    repeat ($urandom_range(0, 2)) rx_stream.push_back(FillerByte);
    repeat ($urandom_range(1, 4)) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3: add_binary($urandom_range(0, 24), $urandom_range(0, 5) == 0, 1'b0);
        4, 5, 6:    add_sentence($urandom_range(0, 30));
        7:          repeat ($urandom_range(1, 4))
                      rx_stream.push_back(8'($urandom_range(0, 255)));
        8:          repeat ($urandom_range(1, 3)) rx_stream.push_back(FillerByte);
        default:    add_binary($urandom_range(0, 24), 1'b0, 1'b1);
      endcase
    end
    play(n_tx, ro, 1'b0);
  endtask

  // Writes all three registers, optionally preceded by a write to the spare
  // index. The upper data bits of the 8-bit registers carry random junk.
  task automatic load_regs(input logic [7:0] start_ch, input logic [7:0] sync_ch,
                           input logic [15:0] limit, input bit spare);
    logic [1:0]  idx[4];
    logic [15:0] val[4];
    int          first;
    idx[0] = CfgSpare;
    val[0] = 16'($urandom_range(0, 65535));
    idx[1] = CFG_TEXT_START;
    val[1] = {8'($urandom_range(0, 255)), start_ch};
    idx[2] = CFG_BIN_SYNC;
    val[2] = {8'($urandom_range(0, 255)), sync_ch};
    idx[3] = CFG_BYTE_LIMIT;
    val[3] = limit;
    first  = spare ? 0 : 1;
    for (int k = first; k < 4; k++) begin
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      cfg_valid <= 1'b1;
      do @(posedge clk); while (!cfg_ready);
    end
    cfg_valid  <= 1'b0;
    cur_start  = start_ch;
    cur_sync   = sync_ch;
    n_settings++;
  endtask

  // Lets every outstanding result drain before the registers are touched.
  // Every exchange gives a result, so waiting until none is pending suffices.
  task automatic settle();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
  endtask

  // Result side: a random wait before each result, with stretches of no
  // waiting, and once a long hold-off so that the block fills and stalls
  // its input while the sender keeps offering.
  initial begin : result_side
    int  gap;
    int  taken;
    bit  calm;
    taken = 0;
    calm  = 1'b0;
    m_tready <= 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken == 500) begin
        m_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk);
      end
      if ($urandom_range(0, 31) == 0) calm = !calm;
      gap = calm ? 0 : $urandom_range(0, 14);
      if (gap > 0) begin
        m_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      taken++;
    end
  end

  initial begin : stimulus
    logic [7:0] pick;
    int         waited;
    n_sent     = 0;
    n_settings = 0;
    s_calm     = 1'b0;
    cur_start  = TextStartReset;
    cur_sync   = BinSyncReset;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= '0;
    s_tlast   <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed opening with the reset register values.
    // Filler on a read-only transaction ends it with no data.
    offer(mk_item(FillerByte, 8'h00, 1'b0, 1'b0, 1'b1, 1'b1));
    // Filler while the host packet is going out.
    offer(mk_item(FillerByte, 8'hFF, 1'b1, 1'b0, 1'b0, 1'b1));
    // Unknown byte on the final host byte: nothing follows, so it ends.
    offer(mk_item(8'h00, 8'hA5, 1'b1, 1'b1, 1'b0, 1'b0));
    // A sentence completed while sending does not end the transaction.
    offer(mk_item(cur_start, 8'h01, 1'b1, 1'b0, 1'b0, 1'b1));
    offer(mk_item(NewlineByte, 8'h02, 1'b1, 1'b0, 1'b0, 1'b0));
    // A sentence received only ends it with status done.
    add_sentence(1);
    play(0, 1'b1, 1'b1);
    // Empty binary frames, good and with a bad checksum.
    add_binary(0, 1'b0, 1'b0);
    play(0, 1'b1, 1'b1);
    add_binary(0, 1'b1, 1'b0);
    play(0, 1'b1, 1'b1);
    settle();

    // Random transactions under a range of settings, the extremes among
    // them: coinciding start and sync characters, a start or sync equal to
    // filler, a newline as start character and the smallest byte limit.
    for (int p = 0; p < 8; p++) begin
      case (p)
        0: load_regs(TextStartReset, BinSyncReset, ByteLimitReset, 1'b1);
        1: load_regs(8'h00, 8'h00, 16'd1, 1'b0);
        2: load_regs(8'hFF, 8'hFF, 16'hFFFF, 1'b1);
        3: load_regs(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     16'($urandom_range(1, 65535)), 1'b0);
        4: load_regs(TextStartReset, BinSyncReset, 16'd20, 1'b1);
        5: load_regs(NewlineByte, BinSyncReset, 16'd300, 1'b0);
        6: begin
          pick = 8'($urandom_range(0, 255));
          load_regs(pick, pick, 16'($urandom_range(2, 100)), 1'b1);
        end
        default: load_regs(TextStartReset, FillerByte, 16'd5000, 1'b0);
      endcase
      waited = n_sent + PhaseItems;
      while (n_sent < waited) random_transaction();
      settle();
    end

    // A binary frame with a two-byte length that runs past the end of the
    // message store.
    load_regs(TextStartReset, BinSyncReset, 16'hFFFF, 1'b0);
    add_binary(1020, 1'b0, 1'b0);
    play(0, 1'b1, 1'b1);

    // Drain, with a bound, then let the output register settle.
    s_tvalid <= 1'b0;
    waited = 0;
    do begin
      @(posedge clk);
      waited++;
    end while (pending != 0 && waited < 20000);
    repeat (4) @(posedge clk);

    $display("Run covered %0d exchanges under %0d register settings, one long frame included.",
             n_results, n_settings);
    $display("Framed %0d sentences, %0d good and %0d corrupt binary frames, %0d ends.",
             n_text, n_bin_ok, n_bin_bad, n_ends);
    if (mismatches == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // Hard stop well beyond the slowest correct run.
  initial begin : watchdog
    #500_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
